/* rtl/core/atp_pkg.sv */
// ----------------------------------------------------------------------------
// atp_pkg: shared types and constants for the fixed-point atan2 pipeline
// Widths, register indexes and coefficient sets used by the stage modules and the top level.
// ----------------------------------------------------------------------------
package atp_pkg;

  localparam int MAG_W     = 17;
  localparam int REM_W     = 18;
  localparam int Q_W       = 15;
  localparam int DIV_STEPS = 15;
  localparam int ACC_W     = 36;
  localparam int PROD_W    = 34;
  localparam int R_W       = 24;
  localparam int ANG_W     = 17;
  localparam int COEF_W    = 18;

  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_PI      = 2'd1;
  localparam logic [1:0] REG_HALF_PI = 2'd2;

  localparam logic signed [COEF_W-1:0] C1_LO = 18'sd580;
  localparam logic signed [COEF_W-1:0] C2_LO = -18'sd1406;
  localparam logic signed [COEF_W-1:0] C3_LO = -18'sd66;
  localparam logic signed [COEF_W-1:0] C4_LO = 18'sd4112;
  localparam logic signed [COEF_W-1:0] C5_LO = -18'sd4096;
  localparam logic signed [COEF_W-1:0] C1_HI = 18'sd2310;
  localparam logic signed [COEF_W-1:0] C2_HI = -18'sd5625;
  localparam logic signed [COEF_W-1:0] C3_HI = -18'sd266;
  localparam logic signed [COEF_W-1:0] C4_HI = 18'sd16447;
  localparam logic signed [COEF_W-1:0] C5_HI = -18'sd49152;

  localparam logic signed [R_W-1:0] ANGLE_MAX = 24'sd65535;
  localparam logic signed [R_W-1:0] ANGLE_MIN = -24'sd65536;

  typedef struct packed {
    logic xzero;
    logic yzero;
    logic xneg;
    logic yneg;
    logic swap;
  } ctl_t;

endpackage

/* rtl/core/atp_prep.sv */
// ----------------------------------------------------------------------------
// atp_prep: magnitude and octant stage
// Takes absolute values, orders them into min and max, records the octant.
// ----------------------------------------------------------------------------
module atp_prep (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [atp_pkg::MAG_W-1:0]  y,
  input  logic signed [atp_pkg::MAG_W-1:0]  x,
  output logic [atp_pkg::MAG_W-1:0]         mn,
  output logic [atp_pkg::MAG_W-1:0]         mx,
  output atp_pkg::ctl_t                     ctl
);

  logic signed [atp_pkg::MAG_W:0] ny;
  logic signed [atp_pkg::MAG_W:0] nx;
  logic [atp_pkg::MAG_W-1:0]      ay;
  logic [atp_pkg::MAG_W-1:0]      ax;

  always_comb begin
    ny = -(atp_pkg::MAG_W+1)'(y);
    nx = -(atp_pkg::MAG_W+1)'(x);
    ay = y[atp_pkg::MAG_W-1] ? ny[atp_pkg::MAG_W-1:0] : y[atp_pkg::MAG_W-1:0];
    ax = x[atp_pkg::MAG_W-1] ? nx[atp_pkg::MAG_W-1:0] : x[atp_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mn        <= (ay < ax) ? ay : ax;
      mx        <= (ay < ax) ? ax : ay;
      ctl.xzero <= (x == '0);
      ctl.yzero <= (y == '0);
      ctl.xneg  <= x[atp_pkg::MAG_W-1];
      ctl.yneg  <= y[atp_pkg::MAG_W-1];
      ctl.swap  <= (ay > ax);
    end
  end

endmodule

/* rtl/core/atp_div_stage.sv */
// ----------------------------------------------------------------------------
// atp_div_stage: one restoring division step
// Produces one quotient bit of min * 2^14 / max per stage.
// ----------------------------------------------------------------------------
module atp_div_stage #(
  parameter bit FIRST = 1'b0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [atp_pkg::REM_W-1:0]     rem_in,
  input  logic [atp_pkg::MAG_W-1:0]     mx_in,
  input  logic [atp_pkg::Q_W-1:0]       q_in,
  input  atp_pkg::ctl_t                 ctl_in,
  output logic [atp_pkg::REM_W-1:0]     rem_out,
  output logic [atp_pkg::MAG_W-1:0]     mx_out,
  output logic [atp_pkg::Q_W-1:0]       q_out,
  output atp_pkg::ctl_t                 ctl_out
);

  logic [atp_pkg::REM_W-1:0] t;
  logic                      ge;

  always_comb begin
    t  = FIRST ? rem_in : {rem_in[atp_pkg::REM_W-2:0], 1'b0};
    ge = (t >= atp_pkg::REM_W'(mx_in));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? (t - atp_pkg::REM_W'(mx_in)) : t;
      q_out   <= {q_in[atp_pkg::Q_W-2:0], ge};
      mx_out  <= mx_in;
      ctl_out <= ctl_in;
    end
  end

endmodule

/* rtl/core/atp_poly.sv */
// ----------------------------------------------------------------------------
// atp_poly: power chain and coefficient accumulation
// Five stages: truncated powers of the ratio, then one multiply-add in each of the last four.
// ----------------------------------------------------------------------------
module atp_poly (
  input  logic                              clk,
  input  logic                              en,
  input  logic                              mode,
  input  logic [atp_pkg::Q_W-1:0]           q,
  input  atp_pkg::ctl_t                     ctl_in,
  output logic signed [atp_pkg::ACC_W-1:0]  acc_out,
  output atp_pkg::ctl_t                     ctl_out
);

  logic [atp_pkg::Q_W-1:0] a0;
  logic [atp_pkg::Q_W-1:0] a_1, a2_1, a_2, a2_2, a3_2, a3_3, a4_3, a4_4;
  logic signed [atp_pkg::ACC_W-1:0] acc_2, acc_3, acc_4;
  atp_pkg::ctl_t ctl_1, ctl_2, ctl_3, ctl_4;

  logic [2*atp_pkg::Q_W-1:0] sq1, sq2, sq3;
  logic signed [atp_pkg::Q_W:0] as2, a2s3, a3s4, a4s5;
  logic signed [atp_pkg::COEF_W-1:0] c1, c2, c3, c4, c5;
  logic signed [atp_pkg::PROD_W-1:0] p2, p3, p4, p5;

  always_comb begin
    a0   = mode ? q : (q >> 2);
    c1   = mode ? atp_pkg::C1_HI : atp_pkg::C1_LO;
    c2   = mode ? atp_pkg::C2_HI : atp_pkg::C2_LO;
    c3   = mode ? atp_pkg::C3_HI : atp_pkg::C3_LO;
    c4   = mode ? atp_pkg::C4_HI : atp_pkg::C4_LO;
    c5   = mode ? atp_pkg::C5_HI : atp_pkg::C5_LO;
    sq1  = a0 * a0;
    sq2  = a2_1 * a_1;
    sq3  = a3_2 * a_2;
    as2  = $signed({1'b0, a_1});
    a2s3 = $signed({1'b0, a2_2});
    a3s4 = $signed({1'b0, a3_3});
    a4s5 = $signed({1'b0, a4_4});
    p2   = c4 * as2;
    p3   = c3 * a2s3;
    p4   = c2 * a3s4;
    p5   = c1 * a4s5;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_1     <= a0;
      a2_1    <= mode ? sq1[14 +: atp_pkg::Q_W] : sq1[12 +: atp_pkg::Q_W];
      ctl_1   <= ctl_in;

      a_2     <= a_1;
      a2_2    <= a2_1;
      a3_2    <= mode ? sq2[14 +: atp_pkg::Q_W] : sq2[12 +: atp_pkg::Q_W];
      acc_2   <= atp_pkg::ACC_W'(p2) + atp_pkg::ACC_W'(c5);
      ctl_2   <= ctl_1;

      a3_3    <= a3_2;
      a4_3    <= mode ? sq3[14 +: atp_pkg::Q_W] : sq3[12 +: atp_pkg::Q_W];
      acc_3   <= acc_2 + atp_pkg::ACC_W'(p3);
      ctl_3   <= ctl_2;

      a4_4    <= a4_3;
      acc_4   <= acc_3 + atp_pkg::ACC_W'(p4);
      ctl_4   <= ctl_3;

      acc_out <= acc_4 + atp_pkg::ACC_W'(p5);
      ctl_out <= ctl_4;
    end
  end

endmodule

/* rtl/core/atp_fold.sv */
// ----------------------------------------------------------------------------
// atp_fold: scale-down, octant unfold and saturation
// Two stages: floor shift with half-pi fold, then quadrant fold and clamp.
// ----------------------------------------------------------------------------
module atp_fold (
  input  logic                              clk,
  input  logic                              en,
  input  logic                              mode,
  input  logic [15:0]                       pi_val,
  input  logic [14:0]                       half_val,
  input  logic signed [atp_pkg::ACC_W-1:0]  acc,
  input  atp_pkg::ctl_t                     ctl_in,
  output logic signed [atp_pkg::ANG_W-1:0]  angle
);

  logic signed [atp_pkg::ACC_W-1:0] sh;
  logic signed [atp_pkg::R_W-1:0]   r0, r1, half_s, pi_s, r2, r3, res;
  atp_pkg::ctl_t                    ctl1;

  always_comb begin
    sh     = mode ? (acc >>> 14) : (acc >>> 12);
    r0     = sh[atp_pkg::R_W-1:0];
    half_s = $signed(atp_pkg::R_W'(half_val));
    pi_s   = $signed(atp_pkg::R_W'(pi_val));
    r2     = ctl1.xneg ? (pi_s - r1) : r1;
    r3     = ctl1.yneg ? -r2 : r2;
    if (ctl1.xzero) begin
      res = ctl1.yzero ? '0 : (ctl1.yneg ? -half_s : half_s);
    end else if (ctl1.yzero) begin
      res = ctl1.xneg ? pi_s : '0;
    end else begin
      res = r3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1    <= ctl_in.swap ? (half_s - r0) : r0;
      ctl1  <= ctl_in;
      if (res > atp_pkg::ANGLE_MAX) begin
        angle <= atp_pkg::ANGLE_MAX[atp_pkg::ANG_W-1:0];
      end else if (res < atp_pkg::ANGLE_MIN) begin
        angle <= atp_pkg::ANGLE_MIN[atp_pkg::ANG_W-1:0];
      end else begin
        angle <= res[atp_pkg::ANG_W-1:0];
      end
    end
  end

endmodule

/* rtl/core/fixed_point_atan2_poly.sv */
// ----------------------------------------------------------------------------
// fixed_point_atan2_poly: pipelined four-quadrant arctangent
// Fourth-order polynomial atan2 with 12 or 14 fraction bits.
// ----------------------------------------------------------------------------
// Input words carry y_value and x_value on s_tdata; each result word carries
// the angle on m_tdata. Configuration writes (mode, pi, half pi) go through
// cfg_we / cfg_addr / cfg_wdata; the user must make them only while the
// pipeline is empty, which the block itself does not enforce. The pipeline
// has 23 register stages: one for magnitudes, fifteen restoring division
// steps (one quotient bit each), five for the power chain and
// multiply-accumulate, two for unfold and clamp. One word is accepted per
// cycle unless the output stalls. The division steps set the depth.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated. Reset empties the pipeline
// and loads mode 0, pi = 12868 and half pi = 6434.
// ----------------------------------------------------------------------------
module fixed_point_atan2_poly #(
  parameter int IN_WIDTH = 17
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // y_value[16:0], x_value[33:17], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // angle[16:0], zero pad
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int DEPTH = 1 + atp_pkg::DIV_STEPS + 5 + 2;
  localparam int EXT   = atp_pkg::MAG_W - IN_WIDTH;

  logic             mode;
  logic [15:0]      pi_val;
  logic [14:0]      half_val;
  logic [DEPTH-1:0] vld;
  logic             en;

  logic signed [atp_pkg::MAG_W-1:0] y_in, x_in;
  logic [atp_pkg::MAG_W-1:0]        mn0;

  logic [atp_pkg::REM_W-1:0] rem [atp_pkg::DIV_STEPS+1];
  logic [atp_pkg::MAG_W-1:0] mx  [atp_pkg::DIV_STEPS+1];
  logic [atp_pkg::Q_W-1:0]   q   [atp_pkg::DIV_STEPS+1];
  atp_pkg::ctl_t             ctl [atp_pkg::DIV_STEPS+1];

  logic signed [atp_pkg::ACC_W-1:0] acc;
  atp_pkg::ctl_t                    ctl_p;
  logic signed [atp_pkg::ANG_W-1:0] angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= 1'b0;
      pi_val   <= 16'd12868;
      half_val <= 15'd6434;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        atp_pkg::REG_MODE:    mode     <= cfg_wdata[0];
        atp_pkg::REG_PI:      pi_val   <= cfg_wdata;
        atp_pkg::REG_HALF_PI: half_val <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  assign en       = !vld[DEPTH-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[DEPTH-1];
  assign m_tdata  = {7'd0, angle};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], s_tvalid};
    end
  end

  always_comb begin
    y_in = $signed(s_tdata[16:0] << EXT) >>> EXT;
    x_in = $signed(s_tdata[33:17] << EXT) >>> EXT;
  end

  atp_prep u_prep (
    .clk (clk),
    .en  (en),
    .y   (y_in),
    .x   (x_in),
    .mn  (mn0),
    .mx  (mx[0]),
    .ctl (ctl[0])
  );

  assign rem[0] = atp_pkg::REM_W'(mn0);
  assign q[0]   = '0;

  for (genvar i = 0; i < atp_pkg::DIV_STEPS; i++) begin : g_div
    atp_div_stage #(.FIRST(i == 0)) u_div (
      .clk     (clk),
      .en      (en),
      .rem_in  (rem[i]),
      .mx_in   (mx[i]),
      .q_in    (q[i]),
      .ctl_in  (ctl[i]),
      .rem_out (rem[i+1]),
      .mx_out  (mx[i+1]),
      .q_out   (q[i+1]),
      .ctl_out (ctl[i+1])
    );
  end

  atp_poly u_poly (
    .clk     (clk),
    .en      (en),
    .mode    (mode),
    .q       (q[atp_pkg::DIV_STEPS]),
    .ctl_in  (ctl[atp_pkg::DIV_STEPS]),
    .acc_out (acc),
    .ctl_out (ctl_p)
  );

  atp_fold u_fold (
    .clk      (clk),
    .en       (en),
    .mode     (mode),
    .pi_val   (pi_val),
    .half_val (half_val),
    .acc      (acc),
    .ctl_in   (ctl_p),
    .angle    (angle)
  );

  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted word did not enter the pipeline");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during a stall");

  a_ratio: assert property (@(posedge clk) disable iff (rst)
    vld[atp_pkg::DIV_STEPS] && !ctl[atp_pkg::DIV_STEPS].xzero
      && !ctl[atp_pkg::DIV_STEPS].yzero |-> q[atp_pkg::DIV_STEPS] <= 15'd16384)
    else $error("ratio above one after division");

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench for fixed_point_atan2_poly
// Drives y/x words with random gaps and output stalls and predicts each angle
// with an independent polynomial atan2 model. It runs several register
// settings, including both modes and the extreme pi values.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class angle_board;
  bit [16:0] pending_angles[$];
  int errors;
  bit mode;
  bit [15:0] pi_q;
  bit [14:0] half_pi_q;

  function void set_reg(bit [1:0] idx, bit [15:0] val);
    if (idx == atp_pkg::REG_MODE) mode = val[0];
    else if (idx == atp_pkg::REG_PI) pi_q = val;
    else if (idx == atp_pkg::REG_HALF_PI) half_pi_q = val[14:0];
  endfunction

  function longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function void note_input(bit [16:0] yw, bit [16:0] xw);
    longint y, x, ay, ax, mn, mx, a, a2, a3, a4, r;
    longint c1, c2, c3, c4, c5;
    int s;
    y = longint'($signed(yw));
    x = longint'($signed(xw));
    s = mode ? 14 : 12;
    if (mode) begin
      c1 = 2310; c2 = -5625; c3 = -266; c4 = 16447; c5 = -49152;
    end else begin
      c1 = 580; c2 = -1406; c3 = -66; c4 = 4112; c5 = -4096;
    end
    if (x == 0) begin
      r = (y == 0) ? 0 : (y > 0 ? longint'(half_pi_q) : -longint'(half_pi_q));
    end else if (y == 0) begin
      r = (x > 0) ? 0 : longint'(pi_q);
    end else begin
      ay = y < 0 ? -y : y;
      ax = x < 0 ? -x : x;
      mn = ay < ax ? ay : ax;
      mx = ay < ax ? ax : ay;
      a = (mn << s) / mx;
      a2 = (a * a) >> s;
      a3 = (a2 * a) >> s;
      a4 = (a3 * a) >> s;
      r = floor_sh(a4 * c1 + a3 * c2 + a2 * c3 + a * c4 + c5, s);
      if (ay > ax) r = longint'(half_pi_q) - r;
      if (x < 0) r = longint'(pi_q) - r;
      if (y < 0) r = -r;
    end
    if (r > 65535) r = 65535;
    if (r < -65536) r = -65536;
    pending_angles.push_back(r[16:0]);
  endfunction

  function void check_result(bit [16:0] got);
    bit [16:0] exp_a;
    if (pending_angles.size() == 0) begin
      $error("angle: unexpected word, actual %0d", $signed(got));
      errors++;
      return;
    end
    exp_a = pending_angles.pop_front();
    if (exp_a != got) begin
      $error("angle: expected %0d, actual %0d", $signed(exp_a), $signed(got));
      errors++;
    end
  endfunction
endclass

module tb;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [39:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [23:0] m_tdata;
  logic cfg_we = 0;
  logic [1:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  angle_board board;
  bit rx_hold = 0;
  bit rx_no_idle = 0;
  bit tx_no_idle = 0;
  int idle_cycles = 0;
  int rx_idle = 0;

  fixed_point_atan2_poly dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) board.check_result(m_tdata[16:0]);
      if (rx_hold) begin
        m_tready <= 0;
      end else if (rx_idle > 0) begin
        rx_idle--;
        m_tready <= 0;
      end else if (!rx_no_idle && $urandom_range(0, 5) == 0) begin
        rx_idle = $urandom_range(0, 3);
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 5000) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(bit [1:0] idx, bit [15:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    board.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic send_word(bit [16:0] yw, bit [16:0] xw);
    int gap;
    if (!tx_no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {6'b0, xw, yw};
    do @(posedge clk); while (!s_tready);
    board.note_input(yw, xw);
  endtask

  task automatic drain;
    s_tvalid <= 0;
    while (board.pending_angles.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic bit [16:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 17'h0;
      1: return 17'h10000;
      2: return 17'h0FFFF;
      3: return 17'($signed($urandom_range(0, 64)) - 32);
      default: return 17'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n);
    bit [16:0] yw, xw;
    repeat (n) begin
      yw = rand_comp();
      xw = rand_comp();
      if ($urandom_range(0, 7) == 0) xw = yw;
      else if ($urandom_range(0, 7) == 0) xw = -yw;
      send_word(yw, xw);
    end
  endtask

  initial begin
    bit [16:0] dy[$] = '{17'h0, 17'h0, 17'h0, 17'h0, 17'h0, 17'h0FFFF, 17'h10000,
                         17'h00005, 17'h1FFFB, 17'h0FFFF, 17'h10000, 17'h10000,
                         17'h00001, 17'h0FFFF, 17'h00003};
    bit [16:0] dx[$] = '{17'h0, 17'h00007, 17'h1FFF9, 17'h0FFFF, 17'h10000, 17'h0,
                         17'h0, 17'h00005, 17'h1FFFB, 17'h10000, 17'h0FFFF,
                         17'h10000, 17'h0FFFF, 17'h00001, 17'h1FFFE};
    board = new();
    board.set_reg(atp_pkg::REG_MODE, 0);
    board.set_reg(atp_pkg::REG_PI, 12868);
    board.set_reg(atp_pkg::REG_HALF_PI, 6434);
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (dy[i]) send_word(dy[i], dx[i]);
    drain();

    write_reg(atp_pkg::REG_MODE, 1);
    write_reg(atp_pkg::REG_PI, 51472);
    write_reg(atp_pkg::REG_HALF_PI, 25736);
    foreach (dy[i]) send_word(dy[i], dx[i]);
    random_phase(150);
    drain();

    write_reg(atp_pkg::REG_PI, 16'hFFFF);
    write_reg(atp_pkg::REG_HALF_PI, 16'hFFFF);
    random_phase(100);
    fork
      begin
        rx_hold = 1;
        repeat (80) @(posedge clk);
        rx_hold = 0;
      end
      random_phase(60);
    join
    drain();

    write_reg(atp_pkg::REG_MODE, 0);
    write_reg(atp_pkg::REG_PI, 0);
    write_reg(atp_pkg::REG_HALF_PI, 0);
    random_phase(100);
    drain();

    write_reg(atp_pkg::REG_MODE, 16'hFFFE);
    write_reg(atp_pkg::REG_PI, 12868);
    write_reg(atp_pkg::REG_HALF_PI, 6434);
    random_phase(200);
    rx_no_idle = 1;
    tx_no_idle = 1;
    random_phase(100);
    drain();

    if (board.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
